// ===== design/ocs_pkg.sv =====
// Shared constants, types and helper functions of the orbit camera unit.
`default_nettype none

package ocs_pkg;

	// Action codes carried on the input tuser.
	localparam logic [2:0] ACT_LEFT     = 3'd0;
	localparam logic [2:0] ACT_RIGHT    = 3'd1;
	localparam logic [2:0] ACT_UP       = 3'd2;
	localparam logic [2:0] ACT_DOWN     = 3'd3;
	localparam logic [2:0] ACT_FORWARD  = 3'd4;
	localparam logic [2:0] ACT_BACKWARD = 3'd5;
	localparam logic [2:0] ACT_LOAD     = 3'd6;

	// Angles in Q16.16 degrees.
	localparam logic [25:0] DEG_FULL  = 26'd23592960;
	localparam logic [23:0] DEG_HALF  = 24'd11796480;
	localparam logic [22:0] DEG_QUART = 23'd5898240;

	localparam logic signed [31:0] DEG_FULL_S  = 32'sd23592960;
	localparam logic signed [31:0] DEG_HALF_S  = 32'sd11796480;
	localparam logic signed [31:0] DEG_QUART_S = 32'sd5898240;

	// 65536 * 180 / pi, rounded.
	localparam logic [21:0] RAD_TO_DEG = 22'd3754936;

	// Inverse CORDIC gain in Q2.30.
	localparam logic signed [47:0] CORDIC_INV_GAIN = 48'sd652032874;

	// Vectoring prescale stops once a magnitude reaches 2^40.
	localparam logic signed [47:0] NORM_LIMIT = 48'sh0100_0000_0000;

	// Request into the CORDIC unit.
	typedef struct packed {
		logic               start;
		logic               vector_mode;
		logic [24:0]        ang;
		logic signed [33:0] num;
		logic signed [33:0] den;
	} cordic_req_t;

	// Response from the CORDIC unit.
	typedef struct packed {
		logic               done;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
	} cordic_rsp_t;

	// atan(2^-i) in Q16.16 degrees.
	function automatic logic [21:0] atan_deg(input logic [4:0] idx);
		logic [21:0] r;
		case (idx)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [37:0] v);
		logic [31:0] r;
		if (v > 38'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -38'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/ocs_divider.sv =====
// Bit-serial divider that also folds the quotient modulo a full turn.
`default_nettype none

module ocs_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [53:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [24:0]      deg
);

	localparam int DIV_BITS = 54;
	localparam logic [25:0] DEG_FULL_W = ocs_pkg::DEG_FULL;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [53:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [24:0] deg_q;

	logic [32:0] trial;
	logic        qbit;
	logic [32:0] diff;
	logic [31:0] rem_n;
	logic [25:0] dbl;
	logic [24:0] deg_n;

	// One quotient bit per cycle; the quotient is kept reduced mod 360 degrees.
	always_comb begin
		trial = {rem_q, dvd_q[53]};
		qbit  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
		rem_n = qbit ? diff[31:0] : trial[31:0];
		dbl   = {deg_q, qbit};
		deg_n = (dbl >= DEG_FULL_W) ? 25'(dbl - DEG_FULL_W) : dbl[24:0];
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			deg_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[52:0], 1'b0};
			rem_q <= rem_n;
			deg_q <= deg_n;
		end
	end

	assign done = done_q;
	assign deg  = deg_q;

endmodule

`default_nettype wire

// ===== design/ocs_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module ocs_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] rad,
	output logic             done,
	output logic [31:0]      root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;

	logic [33:0] t;
	logic [33:0] trial;
	logic        ge;

	// Bring down two bits and try the next root bit.
	always_comb begin
		t     = {rem_q[31:0], rad_q[63:62]};
		trial = {root_q, 2'b01};
		ge    = t >= trial;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? (t - trial) : t;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== design/ocs_cordic.sv =====
// Iterative CORDIC for sine/cosine of an angle and for atan2, one step per cycle.
`default_nettype none

module ocs_cordic #(
	parameter int CORDIC_STEPS = 20
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ocs_pkg::cordic_req_t req,
	output ocs_pkg::cordic_rsp_t     rsp
);

	localparam int IW = $clog2(CORDIC_STEPS);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_NORM = 3'b010,
		PH_ITER = 3'b100
	} phase_t;

	phase_t             phase_q;
	logic               done_q;
	logic [IW-1:0]      i_q;
	logic               vm_q;
	logic               flip_q;
	logic signed [47:0] x_q;
	logic signed [47:0] y_q;
	logic signed [31:0] z_q;
	logic signed [31:0] base_q;

	// Start values.
	logic signed [31:0] za;
	logic signed [31:0] zb;
	logic               flip_n;
	logic signed [47:0] num_w;
	logic signed [47:0] den_w;
	logic               special;
	logic signed [31:0] special_z;

	// Step values.
	logic               ccw;
	logic signed [47:0] xs;
	logic signed [47:0] ys;
	logic signed [31:0] at;
	logic               norm_more;

	// Fold the angle into -90..90 degrees and sort out the atan2 special cases.
	always_comb begin
		za     = $signed({7'b0, req.ang});
		zb     = za;
		flip_n = 1'b0;
		if (za > ocs_pkg::DEG_HALF_S) begin
			za = za - ocs_pkg::DEG_FULL_S;
		end
		zb = za;
		if (za > ocs_pkg::DEG_QUART_S) begin
			zb     = za - ocs_pkg::DEG_HALF_S;
			flip_n = 1'b1;
		end else if (za < -ocs_pkg::DEG_QUART_S) begin
			zb     = za + ocs_pkg::DEG_HALF_S;
			flip_n = 1'b1;
		end
		num_w     = 48'(req.num);
		den_w     = 48'(req.den);
		special   = 1'b0;
		special_z = '0;
		if (req.num == 34'sd0) begin
			special   = 1'b1;
			special_z = req.den[33] ? ocs_pkg::DEG_HALF_S : 32'sd0;
		end else if (req.den == 34'sd0) begin
			special   = 1'b1;
			special_z = req.num[33] ? -ocs_pkg::DEG_QUART_S : ocs_pkg::DEG_QUART_S;
		end
	end

	// One micro-rotation.
	always_comb begin
		ccw       = vm_q ? y_q[47] : !z_q[31];
		xs        = x_q >>> i_q;
		ys        = y_q >>> i_q;
		at        = $signed({10'b0, ocs_pkg::atan_deg(5'(i_q))});
		norm_more = (x_q < ocs_pkg::NORM_LIMIT) && (y_q < ocs_pkg::NORM_LIMIT) &&
			(y_q > -ocs_pkg::NORM_LIMIT);
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						i_q <= '0;
						if (!req.vector_mode) begin
							phase_q <= PH_ITER;
						end else if (special) begin
							done_q <= 1'b1;
						end else begin
							phase_q <= PH_NORM;
						end
					end
				end
				PH_NORM: begin
					if (!norm_more) begin
						phase_q <= PH_ITER;
					end
				end
				PH_ITER: begin
					i_q <= i_q + 1'b1;
					if (i_q == IW'(CORDIC_STEPS - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			vm_q <= req.vector_mode;
			if (!req.vector_mode) begin
				x_q    <= ocs_pkg::CORDIC_INV_GAIN;
				y_q    <= '0;
				z_q    <= zb;
				flip_q <= flip_n;
				base_q <= '0;
			end else begin
				flip_q <= 1'b0;
				if (special) begin
					z_q    <= special_z;
					base_q <= '0;
				end else if (den_w < 0) begin
					x_q    <= -den_w;
					y_q    <= -num_w;
					z_q    <= '0;
					base_q <= ocs_pkg::DEG_HALF_S;
				end else begin
					x_q    <= den_w;
					y_q    <= num_w;
					z_q    <= '0;
					base_q <= '0;
				end
			end
		end else if (phase_q == PH_NORM) begin
			if (norm_more) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end else if (phase_q == PH_ITER) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = flip_q ? -x_q[33:0] : x_q[33:0];
	assign rsp.y    = flip_q ? -y_q[33:0] : y_q[33:0];
	assign rsp.z    = base_q + z_q;

endmodule

`default_nettype wire

// ===== design/orbit_camera_spherical_unit_top.sv =====
// Orbit camera unit: state, sequencer, shared multiplier and stream ports.
// Work per word, from the accepting edge to the edge that raises m_axis_tvalid: turns and
// tilts run the 54-step divider, radial moves and zero-radius turns go straight to the CORDIC,
// loads run the 32-step square root up to twice and up to two arc tangents with their prescale,
// and every word then runs the shared CORDIC iterations.
// One word is in work at a time; the next is taken once the result is in the output register.
// Asynchronous active-low reset clears radius, elevation and azimuth to zero.
`default_nettype none

module orbit_camera_spherical_unit_top #(
	parameter int CORDIC_STEPS = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // move_length, point_x, point_y, point_z
	input  wire logic [2:0]   s_axis_tuser,   // action
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,   // out_x, out_y, out_z
	output logic [0:0]        m_axis_tuser    // degenerate
);

	typedef enum logic [23:0] {
		ST_IDLE     = 24'h000001,
		ST_DECODE   = 24'h000002,
		ST_DIV_GO   = 24'h000004,
		ST_DIV_WAIT = 24'h000008,
		ST_SQ_X     = 24'h000010,
		ST_SQ_Z     = 24'h000020,
		ST_SQ_Y     = 24'h000040,
		ST_SQT_GO   = 24'h000080,
		ST_SQT_WAIT = 24'h000100,
		ST_SQH_GO   = 24'h000200,
		ST_SQH_WAIT = 24'h000400,
		ST_ATE_GO   = 24'h000800,
		ST_ATE_WAIT = 24'h001000,
		ST_ATA_GO   = 24'h002000,
		ST_ATA_WAIT = 24'h004000,
		ST_SCE_GO   = 24'h008000,
		ST_SCE_WAIT = 24'h010000,
		ST_SCA_GO   = 24'h020000,
		ST_SCA_WAIT = 24'h040000,
		ST_MUL1     = 24'h080000,
		ST_MUL2     = 24'h100000,
		ST_MUL3     = 24'h200000,
		ST_MUL4     = 24'h400000,
		ST_MUL5     = 24'h800000
	} state_t;

	localparam state_t ST_FINISH_NEXT = ST_IDLE;

	state_t state_q;
	state_t state_n;
	logic   finish_q;
	logic   m_valid_q;

	// Camera state.
	logic [31:0] radius_q;
	logic [23:0] elev_q;
	logic [24:0] azim_q;

	// Item registers.
	logic [2:0]         action_q;
	logic [31:0]        len_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] pz_q;
	logic               degen_q;

	// Work registers.
	logic [63:0]        hsq_q;
	logic [63:0]        tot_q;
	logic [31:0]        root_h_q;
	logic signed [33:0] cb_q;
	logic signed [33:0] sb_q;
	logic signed [33:0] ca_q;
	logic signed [33:0] sa_q;
	logic signed [33:0] rs_q;
	logic [31:0]        res_x_q;
	logic [31:0]        res_y_q;
	logic [31:0]        res_z_q;
	logic signed [67:0] mul_p_q;

	// Output register.
	logic [95:0] m_data_q;
	logic        m_user_q;

	// Units.
	logic        div_start;
	logic        div_done;
	logic [24:0] div_deg;
	logic        sq_start;
	logic [63:0] sq_rad;
	logic        sq_done;
	logic [31:0] sq_root;
	ocs_pkg::cordic_req_t cq;
	ocs_pkg::cordic_rsp_t cr;

	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic               in_acc;
	logic               out_load;

	// Update candidates.
	logic [25:0] az_left;
	logic [25:0] az_right;
	logic [24:0] az_left_w;
	logic [24:0] az_right_w;
	logic [25:0] el_down;
	logic [32:0] r_sum;
	logic signed [31:0] el_clamp;
	logic signed [31:0] az_t1;
	logic signed [31:0] az_t2;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !finish_q;
	assign out_load      = finish_q && (!m_valid_q || m_axis_tready);

	ocs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p_q[53:0]),
		.divisor  (radius_q),
		.done     (div_done),
		.deg      (div_deg)
	);

	ocs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	ocs_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cq),
		.rsp    (cr)
	);

	// Unit requests.
	always_comb begin
		div_start      = state_q == ST_DIV_GO;
		sq_start       = (state_q == ST_SQT_GO) || (state_q == ST_SQH_GO);
		sq_rad         = (state_q == ST_SQT_GO) ? tot_q : hsq_q;
		cq.start       = (state_q == ST_ATE_GO) || (state_q == ST_ATA_GO) ||
			(state_q == ST_SCE_GO) || (state_q == ST_SCA_GO);
		cq.vector_mode = (state_q == ST_ATE_GO) || (state_q == ST_ATA_GO);
		cq.ang         = (state_q == ST_SCE_GO) ? {1'b0, elev_q} : azim_q;
		cq.num         = (state_q == ST_ATE_GO) ? $signed({2'b0, root_h_q}) : 34'(px_q);
		cq.den         = (state_q == ST_ATE_GO) ? 34'(py_q) : 34'(pz_q);
	end

	// Shared multiplier operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DECODE: begin
				if (action_q == ocs_pkg::ACT_LOAD) begin
					mul_a = 34'(px_q);
					mul_b = 34'(px_q);
				end else begin
					mul_a = $signed({2'b0, len_q});
					mul_b = $signed({12'b0, ocs_pkg::RAD_TO_DEG});
				end
			end
			ST_SQ_X: begin
				mul_a = 34'(pz_q);
				mul_b = 34'(pz_q);
			end
			ST_SQ_Z: begin
				mul_a = 34'(py_q);
				mul_b = 34'(py_q);
			end
			ST_MUL1: begin
				mul_a = $signed({2'b0, radius_q});
				mul_b = sb_q;
			end
			ST_MUL2: begin
				mul_a = $signed({2'b0, radius_q});
				mul_b = cb_q;
			end
			ST_MUL3: begin
				mul_a = rs_q;
				mul_b = sa_q;
			end
			ST_MUL4: begin
				mul_a = rs_q;
				mul_b = ca_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Angle and radius updates.
	always_comb begin
		az_left    = {1'b0, azim_q} + ocs_pkg::DEG_FULL - {1'b0, div_deg};
		az_left_w  = (az_left >= ocs_pkg::DEG_FULL) ? 25'(az_left - ocs_pkg::DEG_FULL) :
			az_left[24:0];
		az_right   = {1'b0, azim_q} + {1'b0, div_deg};
		az_right_w = (az_right >= ocs_pkg::DEG_FULL) ? 25'(az_right - ocs_pkg::DEG_FULL) :
			az_right[24:0];
		el_down    = {2'b0, elev_q} + {1'b0, div_deg};
		r_sum      = {1'b0, radius_q} + {1'b0, len_q};
		el_clamp   = cr.z;
		if (cr.z < 32'sd0) begin
			el_clamp = '0;
		end else if (cr.z > ocs_pkg::DEG_HALF_S) begin
			el_clamp = ocs_pkg::DEG_HALF_S;
		end
		az_t1 = (cr.z < 32'sd0) ? cr.z + ocs_pkg::DEG_FULL_S : cr.z;
		az_t2 = (az_t1 >= ocs_pkg::DEG_FULL_S) ? az_t1 - ocs_pkg::DEG_FULL_S : az_t1;
	end

	// Sequencer.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_n = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (action_q) inside
					ocs_pkg::ACT_LEFT, ocs_pkg::ACT_RIGHT, ocs_pkg::ACT_UP,
					ocs_pkg::ACT_DOWN: begin
						state_n = (radius_q == 32'd0) ? ST_SCE_GO : ST_DIV_GO;
					end
					ocs_pkg::ACT_LOAD: state_n = ST_SQ_X;
					default:           state_n = ST_SCE_GO;
				endcase
			end
			ST_DIV_GO:   state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: state_n = div_done ? ST_SCE_GO : ST_DIV_WAIT;
			ST_SQ_X:     state_n = ST_SQ_Z;
			ST_SQ_Z:     state_n = ST_SQ_Y;
			ST_SQ_Y:     state_n = ST_SQT_GO;
			ST_SQT_GO:   state_n = ST_SQT_WAIT;
			ST_SQT_WAIT: begin
				if (sq_done) begin
					state_n = (tot_q == 64'd0) ? ST_SCE_GO : ST_SQH_GO;
				end
			end
			ST_SQH_GO:   state_n = ST_SQH_WAIT;
			ST_SQH_WAIT: state_n = sq_done ? ST_ATE_GO : ST_SQH_WAIT;
			ST_ATE_GO:   state_n = ST_ATE_WAIT;
			ST_ATE_WAIT: begin
				if (cr.done) begin
					state_n = (px_q == 32'sd0 && pz_q == 32'sd0) ? ST_SCE_GO : ST_ATA_GO;
				end
			end
			ST_ATA_GO:   state_n = ST_ATA_WAIT;
			ST_ATA_WAIT: state_n = cr.done ? ST_SCE_GO : ST_ATA_WAIT;
			ST_SCE_GO:   state_n = ST_SCE_WAIT;
			ST_SCE_WAIT: state_n = cr.done ? ST_SCA_GO : ST_SCE_WAIT;
			ST_SCA_GO:   state_n = ST_SCA_WAIT;
			ST_SCA_WAIT: state_n = cr.done ? ST_MUL1 : ST_SCA_WAIT;
			ST_MUL1:     state_n = ST_MUL2;
			ST_MUL2:     state_n = ST_MUL3;
			ST_MUL3:     state_n = ST_MUL4;
			ST_MUL4:     state_n = ST_MUL5;
			ST_MUL5:     state_n = ST_FINISH_NEXT;
			default:     state_n = ST_IDLE;
		endcase
	end

	// Control and camera state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			finish_q  <= 1'b0;
			m_valid_q <= 1'b0;
			radius_q  <= '0;
			elev_q    <= '0;
			azim_q    <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_MUL5) begin
				finish_q <= 1'b1;
			end else if (out_load) begin
				finish_q <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			// Radial moves.
			if (state_q == ST_DECODE) begin
				if (action_q == ocs_pkg::ACT_FORWARD && radius_q > len_q) begin
					radius_q <= radius_q - len_q;
				end else if (action_q == ocs_pkg::ACT_BACKWARD) begin
					radius_q <= r_sum[32] ? 32'hFFFF_FFFF : r_sum[31:0];
				end
			end

			// Turns and tilts.
			if (state_q == ST_DIV_WAIT && div_done) begin
				case (action_q)
					ocs_pkg::ACT_LEFT:  azim_q <= az_left_w;
					ocs_pkg::ACT_RIGHT: azim_q <= az_right_w;
					ocs_pkg::ACT_UP: begin
						if ({1'b0, elev_q} > div_deg) begin
							elev_q <= 24'({1'b0, elev_q} - div_deg);
						end
					end
					default: begin
						if (el_down < {2'b0, ocs_pkg::DEG_HALF}) begin
							elev_q <= el_down[23:0];
						end
					end
				endcase
			end

			// Loads.
			if (state_q == ST_SQT_WAIT && sq_done) begin
				radius_q <= sq_root;
			end
			if (state_q == ST_ATE_WAIT && cr.done) begin
				elev_q <= el_clamp[23:0];
			end
			if (state_q == ST_ATA_WAIT && cr.done) begin
				azim_q <= az_t2[24:0];
			end
		end
	end

	// Item and work registers.
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (in_acc) begin
			action_q <= s_axis_tuser;
			len_q    <= s_axis_tdata[31:0];
			px_q     <= s_axis_tdata[63:32];
			py_q     <= s_axis_tdata[95:64];
			pz_q     <= s_axis_tdata[127:96];
			degen_q  <= 1'b0;
		end
		if (state_q == ST_DECODE && action_q <= ocs_pkg::ACT_DOWN && radius_q == 32'd0) begin
			degen_q <= 1'b1;
		end
		if (state_q == ST_SQT_WAIT && sq_done && tot_q == 64'd0) begin
			degen_q <= 1'b1;
		end
		if (state_q == ST_ATE_WAIT && cr.done && px_q == 32'sd0 && pz_q == 32'sd0) begin
			degen_q <= 1'b1;
		end
		if (state_q == ST_SQ_X) begin
			hsq_q <= mul_p_q[63:0];
		end
		if (state_q == ST_SQ_Z) begin
			hsq_q <= hsq_q + mul_p_q[63:0];
		end
		if (state_q == ST_SQ_Y) begin
			tot_q <= hsq_q + mul_p_q[63:0];
		end
		if (state_q == ST_SQH_WAIT && sq_done) begin
			root_h_q <= sq_root;
		end
		if (state_q == ST_SCE_WAIT && cr.done) begin
			cb_q <= cr.x;
			sb_q <= cr.y;
		end
		if (state_q == ST_SCA_WAIT && cr.done) begin
			ca_q <= cr.x;
			sa_q <= cr.y;
		end
		if (state_q == ST_MUL2) begin
			rs_q <= mul_p_q[63:30];
		end
		if (state_q == ST_MUL3) begin
			res_y_q <= ocs_pkg::sat32(mul_p_q[67:30]);
		end
		if (state_q == ST_MUL4) begin
			res_x_q <= ocs_pkg::sat32(mul_p_q[67:30]);
		end
		if (state_q == ST_MUL5) begin
			res_z_q <= ocs_pkg::sat32(mul_p_q[67:30]);
		end
		if (out_load) begin
			m_data_q <= {res_z_q, res_y_q, res_x_q};
			m_user_q <= degen_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== design/ocs_checker.sv =====
// Port-level checks of the orbit camera unit and their binding to the top level.
`default_nettype none

module ocs_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [127:0] s_axis_tdata,
	input wire logic [2:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [95:0]  m_axis_tdata,
	input wire logic [0:0]   m_axis_tuser
);

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// After taking a word the unit is not ready in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after an accept");

	// No result can appear in the cycle right after its word is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too early");

endmodule

bind orbit_camera_spherical_unit_top ocs_checker u_ocs_checker (.*);

`default_nettype wire
